@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check themselves; only the engine top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, muted while rst_n is low.
`define BSKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clk edge, reset included.
`define BSKV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bskv_pkg.sv @@
// Package: command and status codes, key info struct, shared constants.
package bskv_pkg;

  localparam int KEY_LEN_W = 7;  // holds a key length up to 127

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_WRITE  = 3'd0;
  localparam cmd_t CMD_READ   = 3'd1;
  localparam cmd_t CMD_KEY    = 3'd2;
  localparam cmd_t CMD_LOOKUP = 3'd3;
  localparam cmd_t CMD_ERASE  = 3'd4;
  localparam cmd_t CMD_HOLE   = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_NO_SPACE  = 2'd2;
  localparam status_t ST_TOO_LONG  = 2'd3;

  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_END   = 1'b1;

  localparam logic [7:0] ERASED      = 8'hFF;
  localparam int         ENTRY_GUARD = 4;

  typedef struct packed {
    logic                 overflow;
    logic [KEY_LEN_W-1:0] eff;  // length up to the first zero character
  } key_info_t;

endpackage

@@ rtl/bskv_in_if.sv @@
// Command channel interface.
interface bskv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [9:0]  byte_addr;
  logic [7:0]  data_byte;
  logic        key_last;
  logic [10:0] hole_size;

  modport source(output valid, cmd, byte_addr, data_byte, key_last, hole_size, input ready);
  modport sink(input valid, cmd, byte_addr, data_byte, key_last, hole_size, output ready);
endinterface

@@ rtl/bskv_out_if.sv @@
// Result channel interface.
interface bskv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic [10:0] result_addr;

  modport source(output valid, status, read_byte, result_addr, input ready);
  modport sink(input valid, status, read_byte, result_addr, output ready);
endinterface

@@ rtl/bskv_mem.sv @@
// Byte store: one write port, one read port, registered read data.
module bskv_mem #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bskv_key.sv @@
// Key buffer: loads key characters and tracks length, overflow and zero cut.
module bskv_key #(
  parameter int KEY_MAX = 16,
  localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [7:0]           data,
  input  logic                 last,
  input  logic [KIW-1:0]       rd_idx,
  output logic [7:0]           rd_char,
  output bskv_pkg::key_info_t  info
);
  import bskv_pkg::*;

  localparam int LW = $clog2(KEY_MAX + 1);

  logic [7:0]           chars_r [KEY_MAX];
  logic [LW-1:0]        len_r, len_base;
  logic [KEY_LEN_W-1:0] eff_r, eff_base;
  logic                 zero_r, zero_base;
  logic                 ovf_r, ovf_base;
  logic                 complete_r;

  // a byte after a finished key starts a new one
  assign len_base  = complete_r ? '0 : len_r;
  assign eff_base  = complete_r ? '0 : eff_r;
  assign zero_base = complete_r ? 1'b0 : zero_r;
  assign ovf_base  = complete_r ? 1'b0 : ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      eff_r      <= '0;
      zero_r     <= 1'b0;
      ovf_r      <= 1'b0;
      complete_r <= 1'b1;
    end else if (load) begin
      len_r      <= len_base;
      eff_r      <= eff_base;
      zero_r     <= zero_base;
      ovf_r      <= ovf_base;
      complete_r <= last;
      if (len_base < LW'(KEY_MAX)) begin
        len_r <= len_base + 1'b1;
        if (!zero_base) begin
          if (data == 8'h00) begin
            zero_r <= 1'b1;
          end else begin
            eff_r <= eff_base + 1'b1;
          end
        end
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && len_base < LW'(KEY_MAX)) begin
      chars_r[len_base[KIW-1:0]] <= data;
    end
  end

  assign rd_char       = chars_r[rd_idx];
  assign info.overflow = ovf_r;
  assign info.eff      = eff_r;

endmodule

@@ rtl/bskv_cfg.sv @@
// Region registers behind the APB-style configuration port.
module bskv_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [9:0]  region_start,
  output logic [10:0] region_end
);
  import bskv_pkg::*;

  logic [9:0]  start_r;
  logic [10:0] end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_REGION_START: start_r <= pwdata[9:0];
        REG_REGION_END:   end_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REGION_START: prdata = {22'd0, start_r};
      REG_REGION_END:   prdata = {21'd0, end_r};
      default:          prdata = '0;
    endcase
  end

  assign region_start = start_r;
  assign region_end   = end_r;

endmodule

@@ rtl/byte_store_key_value_engine.sv @@
// Top level: key/value engine sequencer over the byte store.
//
// Usage
//   in_bus  : command beats (cmd, byte_addr, data_byte, key_last, hole_size).
//   out_bus : one result beat per command (status, read_byte, result_addr).
//   psel/penable/pwrite/paddr/pwdata : region_start at 0, region_end at 4.
// Operation
//   One command at a time. Write, key byte and unused codes go through S_FIN;
//   read goes through S_RD, then S_FIN. Lookup, erase and hole search walk the
//   region one byte per cycle through the single store read port. Each lookup
//   candidate costs one re-read of its first byte, and a mismatch re-reads the
//   key bytes already compared (up to KEY_MAX); each hole step re-reads the
//   byte that ended the free run.
// Reset
//   rst_n (sync, low) starts a clearing pass that writes 0xFF to every store
//   byte, with in_bus.ready low; config writes still go.
// Stall
//   The result sits in an output register; a new command is taken while it
//   waits. A command that finishes while that register is full holds until
//   out_bus.ready takes the older beat.
module byte_store_key_value_engine #(
  parameter int STORE_BYTES = 1024,
  parameter int KEY_MAX     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bskv_in_if.sink     in_bus,
  bskv_out_if.source  out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bskv_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int SW  = ((AW > 11) ? AW : 11) + 2;  // scan address width

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_USED, S_CMP, S_SE1, S_SE2, S_LSE,
    S_WIPE1, S_WIPE2, S_HFREE, S_HUSED, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     a_r, a_nxt;       // address whose byte is in mem_q
  logic [SW-1:0]     s_r, s_nxt;       // entry or hole start
  logic [SW-1:0]     size_r, size_nxt;
  logic [KEY_LEN_W-1:0] i_r, i_nxt;    // key compare index
  logic              erase_r, erase_nxt;
  logic              oob_r, oob_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  status_t           res_st_r, res_st_nxt;
  logic [7:0]        res_byte_r, res_byte_nxt;
  logic [10:0]       res_addr_r, res_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic [10:0]       out_addr_r, out_addr_nxt;

  logic [9:0]        region_start;
  logic [10:0]       region_end;
  logic [SW-1:0]     lo, hi, ext_addr, end_val, e_val;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata, mem_q, d, key_ch;
  logic              at_end;
  logic              in_acc;
  key_info_t         key_info;

  bskv_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .region_start, .region_end
  );

  bskv_key #(.KEY_MAX(KEY_MAX)) u_key (
    .clk, .rst_n,
    .load    (in_acc && in_bus.cmd == CMD_KEY),
    .data    (in_bus.data_byte),
    .last    (in_bus.key_last),
    .rd_idx  (i_r[KIW-1:0]),
    .rd_char (key_ch),
    .info    (key_info)
  );

  bskv_mem #(.DEPTH(STORE_BYTES)) u_mem (
    .clk,
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (a_nxt[AW-1:0]),
    .rdata (mem_q)
  );

  assign pready = 1'b1;

  // effective region end: clipped to the store size
  assign hi = (SW'(region_end) > SW'(STORE_BYTES)) ? SW'(STORE_BYTES) : SW'(region_end);
  assign lo = SW'(region_start);
  assign ext_addr = SW'(in_bus.byte_addr);

  // bytes past the region end look erased
  assign at_end  = (a_r >= hi);
  assign d       = at_end ? ERASED : mem_q;
  // string end seen at a_r
  assign end_val = at_end ? hi : ((d == 8'h00) ? a_r + 1'b1 : a_r);
  assign e_val   = at_end ? hi : a_r;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_comb begin
    state_nxt    = state_r;
    a_nxt        = a_r + 1'b1;
    s_nxt        = s_r;
    size_nxt     = size_r;
    i_nxt        = i_r;
    erase_nxt    = erase_r;
    oob_nxt      = oob_r;
    clr_nxt      = clr_r;
    res_st_nxt   = res_st_r;
    res_byte_nxt = res_byte_r;
    res_addr_nxt = res_addr_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_st_nxt   = out_st_r;
    out_byte_nxt = out_byte_r;
    out_addr_nxt = out_addr_r;
    mem_we       = 1'b0;
    mem_waddr    = a_r[AW-1:0];
    mem_wdata    = ERASED;

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_st_nxt   = ST_OK;
          res_byte_nxt = '0;
          res_addr_nxt = '0;
          state_nxt    = S_FIN;
          case (in_bus.cmd)
            CMD_WRITE: begin
              if (ext_addr < SW'(STORE_BYTES)) begin
                mem_we    = 1'b1;
                mem_waddr = ext_addr[AW-1:0];
                mem_wdata = in_bus.data_byte;
              end
            end
            CMD_READ: begin
              a_nxt     = ext_addr;
              oob_nxt   = (ext_addr >= SW'(STORE_BYTES));
              state_nxt = S_RD;
            end
            CMD_LOOKUP, CMD_ERASE: begin
              erase_nxt = (in_bus.cmd == CMD_ERASE);
              if (key_info.overflow) begin
                res_st_nxt = ST_TOO_LONG;
              end else if (lo + SW'(ENTRY_GUARD) < hi) begin
                a_nxt     = lo;
                state_nxt = S_USED;
              end else begin
                res_st_nxt = ST_NOT_FOUND;
              end
            end
            CMD_HOLE: begin
              size_nxt = SW'(in_bus.hole_size);
              s_nxt    = lo;
              if (lo + SW'(in_bus.hole_size) > hi) begin
                res_st_nxt = ST_NO_SPACE;
              end else begin
                a_nxt     = lo;
                state_nxt = S_HFREE;
              end
            end
            default: ;  // key byte and unused codes answer all zero
          endcase
        end
      end
      S_RD: begin
        res_byte_nxt = oob_r ? ERASED : mem_q;
        state_nxt    = S_FIN;
      end
      S_USED: begin
        if (at_end) begin
          res_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end else if (d != ERASED) begin
          s_nxt     = a_r;
          i_nxt     = '0;
          a_nxt     = a_r;  // re-read first key byte
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (i_r < key_info.eff) begin
          if (d == key_ch) begin
            i_nxt = i_r + 1'b1;
          end else begin
            a_nxt     = s_r + 1'b1;
            state_nxt = S_SE1;
          end
        end else if (d == 8'h00) begin
          if (erase_r) begin
            a_nxt     = s_r;
            state_nxt = S_WIPE1;
          end else begin
            a_nxt     = s_r + 1'b1;
            state_nxt = S_LSE;
          end
        end else begin
          a_nxt     = s_r + 1'b1;
          state_nxt = S_SE1;
        end
      end
      S_SE1, S_SE2, S_LSE: begin
        if (at_end || d == ERASED || d == 8'h00) begin
          if (state_r == S_SE1) begin
            a_nxt     = end_val + 1'b1;
            state_nxt = S_SE2;
          end else if (state_r == S_SE2) begin
            if (end_val + SW'(ENTRY_GUARD) < hi) begin
              a_nxt     = end_val;
              state_nxt = S_USED;
            end else begin
              res_st_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end
          end else begin
            res_addr_nxt = end_val[10:0];
            state_nxt    = S_FIN;
          end
        end
      end
      S_WIPE1, S_WIPE2: begin
        if (d == ERASED) begin
          a_nxt     = a_r;
          state_nxt = (state_r == S_WIPE1) ? S_WIPE2 : S_FIN;
        end else begin
          mem_we = 1'b1;
          if (d == 8'h00) begin
            state_nxt = (state_r == S_WIPE1) ? S_WIPE2 : S_FIN;
          end
        end
      end
      S_HFREE: begin
        if (at_end) begin
          res_st_nxt = ST_NO_SPACE;
          state_nxt  = S_FIN;
        end else if (d == ERASED) begin
          s_nxt     = a_r;
          state_nxt = S_HUSED;
        end
      end
      S_HUSED: begin
        if (at_end || d != ERASED) begin
          if (e_val - s_r >= size_r) begin
            res_addr_nxt = s_r[10:0];
            state_nxt    = S_FIN;
          end else if (e_val + size_r > hi) begin
            res_st_nxt = ST_NO_SPACE;
            state_nxt  = S_FIN;
          end else begin
            s_nxt     = e_val;
            a_nxt     = e_val;
            state_nxt = S_HFREE;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_byte_nxt  = res_byte_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    s_r        <= s_nxt;
    size_r     <= size_nxt;
    i_r        <= i_nxt;
    erase_r    <= erase_nxt;
    oob_r      <= oob_nxt;
    res_st_r   <= res_st_nxt;
    res_byte_r <= res_byte_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_byte_r <= out_byte_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_st_r;
  assign out_bus.read_byte   = out_byte_r;
  assign out_bus.result_addr = out_addr_r;

`include "assert_macros.svh"

  `BSKV_ASSERT(a_clr_blocks_cmds, (state_r == S_CLR) |-> !in_bus.ready, "command taken during clear")
  `BSKV_ASSERT(a_wipe_in_region, (mem_we && (state_r == S_WIPE1 || state_r == S_WIPE2)) |-> (a_r < hi), "erase outside region")
  `BSKV_ASSERT(a_fin_loads_out, (state_r == S_FIN && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE), "result not loaded")
  `BSKV_ASSERT(a_key_eff_bound, key_info.eff <= KEY_LEN_W'(KEY_MAX), "key length past capacity")

endmodule

@@ bench/byte_store_key_value_engine_test.sv @@
// Testbench for byte_store_key_value_engine: directed and random beats against a predictor.
module byte_store_key_value_engine_test;
  import bskv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_SIZE   = 1024;
  localparam int KEY_CAP    = 16;
  localparam int IDLE_LIMIT = 20000;  // covers the clearing pass and the longest scan

  typedef struct packed {
    status_t     status;
    logic [7:0]  read_byte;
    logic [10:0] result_addr;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  bskv_in_if  cmd_ch();
  bskv_out_if res_ch();

  byte_store_key_value_engine dut (
    .clk(clk), .rst_n(rst_n), .in_bus(cmd_ch), .out_bus(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: store image, key buffer, region registers
  // ---------------------------------------------------------------------------
  logic [7:0] store_img [MEM_SIZE];
  logic [7:0] key_buf [KEY_CAP];
  int         key_cnt;
  bit         key_ovf, key_done;
  int         region_lo, region_end_reg;

  result_t expected_results[$];
  int      fail_cnt;
  int      idle_cycles;
  bit      no_idle;      // stretches with back-to-back beats on both sides
  bit      cmd_valid_hi; // tracks our own valid so it is never lowered twice a step

  function automatic int region_hi();
    return region_end_reg > MEM_SIZE ? MEM_SIZE : region_end_reg;
  endfunction

  // searches see everything outside the region top as erased
  function automatic int peek(int a);
    if (a < 0 || a >= region_hi()) return ERASED;
    return store_img[a];
  endfunction

  function automatic int next_used(int a);
    for (; a < region_hi(); a++) if (peek(a) != ERASED) return a;
    return -1;
  endfunction

  function automatic int next_free(int a);
    for (; a < region_hi(); a++) if (peek(a) == ERASED) return a;
    return -1;
  endfunction

  // just past a string: after its zero, or at the first erased byte
  function automatic int string_end(int a);
    int c;
    while (++a < region_hi()) begin
      c = peek(a);
      if (c == ERASED) return a;
      if (c == 0) return a + 1;
    end
    return region_hi();
  endfunction

  function automatic int key_eff_len();
    int n;
    n = key_cnt > KEY_CAP ? KEY_CAP : key_cnt;
    for (int i = 0; i < n; i++) if (key_buf[i] == 8'h00) return i;
    return n;
  endfunction

  function automatic bit key_at(int a);
    int n;
    n = key_eff_len();
    for (int i = 0; i < n; i++) if (peek(a + i) != key_buf[i]) return 1'b0;
    return peek(a + n) == 0;
  endfunction

  function automatic int locate_entry();
    int s;
    s = region_lo;
    while (s < region_hi() - ENTRY_GUARD) begin
      s = next_used(s);
      if (s < 0) return -1;
      if (key_at(s)) return s;
      s = string_end(string_end(s));
    end
    return -1;
  endfunction

  function automatic int wipe_text(int a);
    int c;
    forever begin
      c = peek(a);
      if (c == ERASED) return a;
      store_img[a] = ERASED;
      a++;
      if (c == 0) return a;
    end
  endfunction

  function automatic int locate_hole(int size);
    int s, e;
    s = region_lo;
    forever begin
      if (s + size > region_hi()) return -1;
      s = next_free(s);
      if (s < 0) return -1;
      e = next_used(s);
      if (e < 0) e = region_hi();
      if (e - s >= size) return s;
      s = e;
    end
  endfunction

  // Works out the result of one accepted command and updates the image.
  function automatic result_t engine_predict(cmd_t cmd, logic [9:0] addr, logic [7:0] data,
                                             logic last, logic [10:0] size);
    result_t r;
    int hit;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_WRITE: store_img[addr] = data;
      CMD_READ:  r.read_byte = store_img[addr];
      CMD_KEY: begin
        if (key_done) begin
          key_cnt = 0;
          key_ovf = 1'b0;
          key_done = 1'b0;
        end
        if (key_cnt < KEY_CAP) key_buf[key_cnt++] = data;
        else key_ovf = 1'b1;
        if (last) key_done = 1'b1;
      end
      CMD_LOOKUP, CMD_ERASE: begin
        if (key_ovf) r.status = ST_TOO_LONG;
        else begin
          hit = locate_entry();
          if (hit < 0) r.status = ST_NOT_FOUND;
          else if (cmd == CMD_LOOKUP) r.result_addr = 11'(string_end(hit));
          else void'(wipe_text(wipe_text(hit)));
        end
      end
      CMD_HOLE: begin
        hit = locate_hole(size);
        if (hit < 0) r.status = ST_NO_SPACE;
        else r.result_addr = 11'(hit);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Gaps: mostly none or short, a few long
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Command channel driver: one beat per call
  // ---------------------------------------------------------------------------
  task automatic send_cmd(cmd_t cmd, logic [9:0] addr = '0, logic [7:0] data = '0,
                          logic last = 1'b0, logic [10:0] size = '0);
    int gap;
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd       <= cmd;
    cmd_ch.byte_addr <= addr;
    cmd_ch.data_byte <= data;
    cmd_ch.key_last  <= last;
    cmd_ch.hole_size <= size;
    cmd_valid_hi = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_results.push_back(engine_predict(cmd, addr, data, last, size));
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      cmd_valid_hi = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_text(int addr, string s);
    foreach (s[i]) send_cmd(CMD_WRITE, 10'(addr + i), s[i]);
    send_cmd(CMD_WRITE, 10'(addr + s.len()), 8'h00);
  endtask

  task automatic load_key(string s, bit finish = 1'b1);
    foreach (s[i]) send_cmd(CMD_KEY, '0, s[i], finish && i == s.len() - 1);
  endtask

  // lowers valid and waits for every pending result
  task automatic drain();
    if (cmd_valid_hi) begin
      cmd_ch.valid <= 1'b0;
      cmd_valid_hi = 1'b0;
    end
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // APB write: setup then access, register latched on the access edge
  task automatic cfg_write(logic idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_REGION_START) region_lo = value & 10'h3FF;
    else region_end_reg = value & 11'h7FF;
  endtask

  task automatic set_region(int lo, int hi);
    drain();
    cfg_write(REG_REGION_START, lo);
    cfg_write(REG_REGION_END, hi);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= (pick_gap() == 0);
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_ch.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, res_ch.status);
            fail_cnt++;
          end
          if (res_ch.read_byte !== exp_r.read_byte) begin
            $error("read_byte: expected %0h, got %0h", exp_r.read_byte, res_ch.read_byte);
            fail_cnt++;
          end
          if (res_ch.result_addr !== exp_r.result_addr) begin
            $error("result_addr: expected %0d, got %0d", exp_r.result_addr,
                   res_ch.result_addr);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_byte_access();
    send_cmd(CMD_WRITE, 10'd0, 8'h00);
    send_cmd(CMD_WRITE, 10'h3FF, 8'hAA);
    send_cmd(CMD_WRITE, 10'h2AA, 8'h55);
    send_cmd(CMD_READ, 10'd0);
    send_cmd(CMD_READ, 10'h3FF);
    send_cmd(CMD_READ, 10'h2AA);
    send_cmd(CMD_READ, 10'h155);
    send_cmd(cmd_t'(3'd6), 10'h3FF, 8'hFF, 1'b1, 11'h7FF);
    send_cmd(cmd_t'(3'd7), 10'h155, 8'h5A, 1'b1, 11'h555);
    send_cmd(CMD_WRITE, 10'd0, 8'hFF);
    send_cmd(CMD_WRITE, 10'h3FF, 8'hFF);
    send_cmd(CMD_WRITE, 10'h2AA, 8'hFF);
  endtask

  task automatic test_key_lookup();
    // lookup before any key: empty key against an empty store
    send_cmd(CMD_LOOKUP);
    write_text(40, "ab");
    write_text(43, "xy");
    write_text(46, "k");
    write_text(48, "v");
    load_key("ab");
    send_cmd(CMD_LOOKUP);
    load_key("k");
    send_cmd(CMD_LOOKUP);
    load_key("zz");
    send_cmd(CMD_LOOKUP);
    // zero inside the key cuts it short
    send_cmd(CMD_KEY, '0, "a");
    send_cmd(CMD_KEY, '0, "b");
    send_cmd(CMD_KEY, '0, 8'h00);
    send_cmd(CMD_KEY, '0, "q", 1'b1);
    send_cmd(CMD_LOOKUP);
    // key still being loaded
    load_key("k", 1'b0);
    send_cmd(CMD_LOOKUP);
    send_cmd(CMD_ERASE);
    send_cmd(CMD_KEY, '0, "x", 1'b1);
    // overlong key
    load_key("abcdefghijklmnopq");
    send_cmd(CMD_LOOKUP);
    send_cmd(CMD_ERASE);
    load_key("ab");
    send_cmd(CMD_ERASE);
    send_cmd(CMD_LOOKUP);
  endtask

  task automatic test_hole_search();
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd0);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd1);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd41);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd1024);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd2047);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd976);
  endtask

  task automatic test_region_edges();
    set_region(1023, 2047);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd1);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd2);
    set_region(100, 50);
    send_cmd(CMD_LOOKUP);
    send_cmd(CMD_ERASE);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd1);
    set_region(0, 1);
    send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'd1);
    // entry straddling the region top: erase must stop at the edge
    set_region(200, 210);
    write_text(205, "kk");
    write_text(208, "vvvv");
    load_key("kk");
    send_cmd(CMD_LOOKUP);
    send_cmd(CMD_ERASE);
    send_cmd(CMD_READ, 10'd209);
    set_region(0, 1024);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent, pick, base, span, len;
    string k, v;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 120 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 5);
        if (pick == 0) set_region(0, 1024);
        else if (pick == 1) set_region($urandom_range(0, 1023), $urandom_range(1, 2047));
        else begin
          base = $urandom_range(0, 900);
          set_region(base, base + $urandom_range(20, 124));
        end
      end
      span = region_hi() - region_lo;
      pick = $urandom_range(0, 99);
      if (pick < 70 && span >= 24) begin
        // well-formed: store an entry (two times in three), load a near key, search
        k = ""; v = "";
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) k = {k, string'(8'("a" + $urandom_range(0, 1)))};
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) v = {v, string'(8'("0" + $urandom_range(0, 9)))};
        base = region_lo + $urandom_range(0, span - 12);
        if ($urandom_range(0, 2) != 0) begin
          write_text(base, k);
          write_text(base + k.len() + 1, v);
          sent += k.len() + v.len() + 2;
        end
        if ($urandom_range(0, 3) == 0) k = {k, "a"};
        load_key(k);
        sent += k.len();
        case ($urandom_range(0, 2))
          0: send_cmd(CMD_LOOKUP);
          1: send_cmd(CMD_ERASE);
          default: send_cmd(CMD_HOLE, '0, '0, 1'b0, 11'($urandom_range(0, 12)));
        endcase
        sent++;
      end else begin
        // noise: any field value
        send_cmd(cmd_t'($urandom_range(0, 7)), 10'($urandom), 8'($urandom),
                 1'($urandom), 11'($urandom));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cmd_ch.valid = 1'b0; cmd_ch.cmd = CMD_WRITE; cmd_ch.byte_addr = '0;
    cmd_ch.data_byte = '0; cmd_ch.key_last = 1'b0; cmd_ch.hole_size = '0;
    res_ch.ready = 1'b0;
    fail_cnt = 0; idle_cycles = 0; no_idle = 1'b0; cmd_valid_hi = 1'b0;
    foreach (store_img[i]) store_img[i] = ERASED;
    foreach (key_buf[i]) key_buf[i] = 8'h00;
    key_cnt = 0; key_ovf = 1'b0; key_done = 1'b1;
    region_lo = 0; region_end_reg = 1024;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_access();
    test_key_lookup();
    test_hole_search();
    test_region_edges();
    test_random_traffic(480);

    drain();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
